[rtl/core/alid_pkg.sv]
// ----------------------------------------------------------------------------
// alid_pkg
// shared types and constants of the array list insert/delete core
// ----------------------------------------------------------------------------
package alid_pkg;

	// list geometry
	localparam int CAPACITY = 128;
	localparam int IDXW     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNTW     = $clog2(CAPACITY + 1);
	localparam int LEN_W    = 8;
	localparam int POS_W    = 8;
	localparam int CMP_W    = 16;

	// read-out or tree: lanes per group
	localparam int GRP      = 8;
	localparam int NGRP     = (CAPACITY + GRP - 1) / GRP;

	// stream widths
	localparam int IN_W     = 48;
	localparam int OUT_W    = 48;

	typedef logic [31:0] elem_t;

	// operation codes
	localparam logic [2:0] OP_INS_FRONT = 3'd0;
	localparam logic [2:0] OP_INS_END   = 3'd1;
	localparam logic [2:0] OP_INS_POS   = 3'd2;
	localparam logic [2:0] OP_DEL_POS   = 3'd3;
	localparam logic [2:0] OP_READ      = 3'd4;

	// status codes
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_FULL   = 2'd1;
	localparam logic [1:0] ST_EMPTY  = 2'd2;
	localparam logic [1:0] ST_BADPOS = 2'd3;

	// command broadcast to every cell of the row
	typedef struct packed {
		logic            ins;
		logic            del;
		logic [IDXW-1:0] at;
		elem_t           val;
		logic            rd;
		logic [IDXW-1:0] rd_at;
	} cell_cmd_t;

endpackage

[rtl/core/alid_cell.sv]
// ----------------------------------------------------------------------------
// alid_cell
// one slot of the list: holds an element, shifts with its neighbors
// ----------------------------------------------------------------------------
module alid_cell import alid_pkg::*; (
	input  logic            clk,
	input  logic [IDXW-1:0] idx,
	input  cell_cmd_t       cmd,
	input  elem_t           left,
	input  elem_t           right,
	output elem_t           data,
	output elem_t           tap
);

	elem_t elem_q;

	// insert opens a gap at cmd.at, delete closes it
	always_ff @(posedge clk) begin
		if (cmd.ins && idx == cmd.at) begin
			elem_q <= cmd.val;
		end else if (cmd.ins && idx > cmd.at) begin
			elem_q <= left;
		end else if (cmd.del && idx >= cmd.at) begin
			elem_q <= right;
		end
	end

	assign data = elem_q;
	assign tap  = (cmd.rd && idx == cmd.rd_at) ? elem_q : '0;

endmodule

[rtl/core/alid_chain.sv]
// ----------------------------------------------------------------------------
// alid_chain
// row of list cells plus a registered or-tree that collects a read
// ----------------------------------------------------------------------------
module alid_chain import alid_pkg::*; (
	input  logic      clk,
	input  cell_cmd_t cmd,
	input  logic      ld,
	output elem_t     rd_value
);

	elem_t data [CAPACITY];
	elem_t tap  [CAPACITY];
	elem_t grp_s1 [NGRP];
	elem_t grp_d  [NGRP];

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		elem_t left_w;
		elem_t right_w;
		if (i == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_mid_l
			assign left_w = data[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right_w = data[i];
		end else begin : g_mid_r
			assign right_w = data[i+1];
		end
		alid_cell u_cell (
			.clk   (clk),
			.idx   (IDXW'(i)),
			.cmd   (cmd),
			.left  (left_w),
			.right (right_w),
			.data  (data[i]),
			.tap   (tap[i])
		);
	end

	// first level: or of each group of lanes
	always_comb begin
		for (int g = 0; g < NGRP; g++) begin
			grp_d[g] = '0;
			for (int k = 0; k < GRP; k++) begin
				if (g * GRP + k < CAPACITY) begin
					grp_d[g] = grp_d[g] | tap[g * GRP + k];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			for (int g = 0; g < NGRP; g++) begin
				grp_s1[g] <= grp_d[g];
			end
		end
	end

	// second level: or of the group registers
	always_comb begin
		rd_value = '0;
		for (int g = 0; g < NGRP; g++) begin
			rd_value = rd_value | grp_s1[g];
		end
	end

endmodule

[rtl/core/array_list_insert_delete_core.sv]
// ----------------------------------------------------------------------------
// array_list_insert_delete_core
// fixed-capacity ordered list with positional insert, delete and read
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+---------------------------------------
//  s_*     | in  | s_tvalid/s_tready  | operation, position, value
//  m_*     | out | m_tvalid/m_tready  | status, length, is_empty, is_full,
//          |     |                    | read_value
//
//  an accepted transaction passes the execute state, in which the whole cell
//  row shifts in parallel and a read is captured in the group registers, and
//  the read-out state, in which the or of the group registers feeds the
//  output register; a new transaction is accepted only in the idle state, so
//  one operation is in flight at a time
//  a stalled m_tready holds the finished result, and a new input transaction
//  may be accepted meanwhile; it then waits in the read-out stage
//  arst_n clears the control state and the element count; element storage
//  needs no clearing, only slots below the count are ever read
//
module array_list_insert_delete_core import alid_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	// operation [2:0], position [10:3], value [42:11], zero fill
	input  logic [IN_W-1:0]  s_tdata,
	input  logic             s_tvalid,
	output logic             s_tready,
	// status [1:0], length [9:2], is_empty [10], is_full [11],
	// read_value [43:12], zero fill
	output logic [OUT_W-1:0] m_tdata,
	output logic             m_tvalid,
	input  logic             m_tready
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_RED
	} state_t;

	state_t state_q;

	// captured operation
	logic [2:0]       op_q;
	logic [POS_W-1:0] pos_q;
	elem_t            val_q;

	// list length, the only control state of the list itself
	logic [CNTW-1:0]  count_q;

	// result fields held between execute and read-out
	logic [1:0]       res_status_q;
	logic [CNTW-1:0]  res_count_q;
	logic             res_rd_q;

	// output register
	logic             m_tvalid_q;
	logic [1:0]       out_status_q;
	logic [LEN_W-1:0] out_len_q;
	logic             out_empty_q;
	logic             out_full_q;
	elem_t            out_rd_q;

	// execute-cycle decode
	cell_cmd_t        cmd;
	logic [1:0]       status_d;
	logic [CNTW-1:0]  count_d;
	logic [CMP_W-1:0] pos_w;
	logic [CMP_W-1:0] cnt_w;
	logic             is_full_w;
	logic             is_empty_w;
	logic             ins_pos_ok;
	logic             del_pos_ok;
	logic             exec;
	elem_t            rd_value;

	assign exec       = (state_q == S_EXEC);
	assign pos_w      = CMP_W'(pos_q);
	assign cnt_w      = CMP_W'(count_q);
	assign is_full_w  = (cnt_w == CMP_W'(CAPACITY));
	assign is_empty_w = (count_q == '0);
	assign ins_pos_ok = (pos_w != '0) && (pos_w <= cnt_w + CMP_W'(1));
	assign del_pos_ok = (pos_w != '0) && (pos_w <= cnt_w);

	// status and the command broadcast to the cell row
	always_comb begin
		cmd      = '0;
		cmd.val  = val_q;
		status_d = ST_OK;
		count_d  = count_q;
		case (op_q)
			OP_INS_FRONT: begin
				if (is_full_w) begin
					status_d = ST_FULL;
				end else begin
					cmd.ins = exec;
					cmd.at  = '0;
					count_d = count_q + CNTW'(1);
				end
			end
			OP_INS_END: begin
				if (is_full_w) begin
					status_d = ST_FULL;
				end else begin
					cmd.ins = exec;
					cmd.at  = IDXW'(count_q);
					count_d = count_q + CNTW'(1);
				end
			end
			OP_INS_POS: begin
				if (is_full_w) begin
					status_d = ST_FULL;
				end else if (is_empty_w) begin
					// empty list: position is ignored, goes to the front
					cmd.ins = exec;
					cmd.at  = '0;
					count_d = count_q + CNTW'(1);
				end else if (!ins_pos_ok) begin
					status_d = ST_BADPOS;
				end else begin
					cmd.ins = exec;
					cmd.at  = IDXW'(pos_w - CMP_W'(1));
					count_d = count_q + CNTW'(1);
				end
			end
			OP_DEL_POS: begin
				if (is_empty_w) begin
					status_d = ST_EMPTY;
				end else if (!del_pos_ok) begin
					status_d = ST_BADPOS;
				end else begin
					cmd.del = exec;
					cmd.at  = IDXW'(pos_w - CMP_W'(1));
					count_d = count_q - CNTW'(1);
				end
			end
			OP_READ: begin
				if (is_empty_w) begin
					status_d = ST_EMPTY;
				end else if (!del_pos_ok) begin
					status_d = ST_BADPOS;
				end else begin
					cmd.rd    = exec;
					cmd.rd_at = IDXW'(pos_w - CMP_W'(1));
				end
			end
			default: begin
				// unused codes leave the list alone
				status_d = ST_OK;
			end
		endcase
	end

	alid_chain u_chain (
		.clk      (clk),
		.cmd      (cmd),
		.ld       (exec),
		.rd_value (rd_value)
	);

	// captured payload, no reset needed
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_q  <= s_tdata[2:0];
			pos_q <= s_tdata[10:3];
			val_q <= s_tdata[42:11];
		end
		if (exec) begin
			res_status_q <= status_d;
			res_count_q  <= count_d;
			res_rd_q     <= cmd.rd;
		end
	end

	// sequencer, element count and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			m_tvalid_q   <= 1'b0;
			out_status_q <= ST_OK;
			out_len_q    <= '0;
			out_empty_q  <= 1'b1;
			out_full_q   <= 1'b0;
			out_rd_q     <= '0;
		end else begin
			// in the read-out state a taken result is replaced by the next one
			if (m_tvalid_q && m_tready && state_q != S_RED) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					count_q <= count_d;
					state_q <= S_RED;
				end
				S_RED: begin
					// hand over once the output register is free
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q   <= 1'b1;
						out_status_q <= res_status_q;
						out_len_q    <= LEN_W'(res_count_q);
						out_empty_q  <= (res_count_q == '0);
						out_full_q   <= (CMP_W'(res_count_q) == CMP_W'(CAPACITY));
						out_rd_q     <= res_rd_q ? rd_value : '0;
						state_q      <= S_IDLE;
					end else if (m_tvalid_q && m_tready) begin
						m_tvalid_q <= 1'b0;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {4'b0, out_rd_q, out_full_q, out_empty_q, out_len_q, out_status_q};

endmodule

[test/tb_array_list_insert_delete_core.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_array_list_insert_delete_core
// self-checking bench for the positional insert/delete list core
// ----------------------------------------------------------------------------
//
//  operations go in on the s_* stream and every accepted transaction is run
//  through a shadow copy of the list held in a scoreboard object; the result
//  it predicts is queued and compared field by field against each transaction
//  that leaves on the m_* stream
//  a short directed sequence covers the empty, bad position and unused code
//  cases, then a random walk fills the list to capacity and drains it again
//  several times while both sides idle at random, in three profiles, the last with no idling
//
module tb_array_list_insert_delete_core;
	import alid_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int ITEMS_PER_PHASE = 470;
	localparam int TAIL_CYCLES = 12;

	// one result of the list, as it leaves on m_tdata
	typedef struct {
		logic [1:0]       status;
		logic [LEN_W-1:0] length;
		logic             is_empty;
		logic             is_full;
		elem_t            read_value;
	} list_result_t;

	// shadow list plus the queue of results still owed by the core
	class list_scoreboard;
		elem_t        slots[CAPACITY];
		int unsigned  n_elems;
		list_result_t owed[$];
		int unsigned  failures;

		function new();
			n_elems  = 0;
			failures = 0;
		endfunction

		function int unsigned pending();
			return owed.size();
		endfunction

		// shift slots at..n-1 up by one and drop v into the gap
		function void open_gap(int unsigned at, elem_t v);
			for (int unsigned i = n_elems; i > at; i--)
				slots[i] = slots[i - 1];
			slots[at] = v;
			n_elems++;
		endfunction

		// shift slots above at down by one
		function void close_gap(int unsigned at);
			for (int unsigned i = at; i + 1 < n_elems; i++)
				slots[i] = slots[i + 1];
			n_elems--;
		endfunction

		// apply one accepted operation to the shadow list and queue its result
		function void note_request(logic [2:0] op, logic [POS_W-1:0] pos, elem_t val);
			list_result_t res;
			int unsigned  p;
			res.status     = ST_OK;
			res.read_value = '0;
			p = 32'(pos);
			case (op)
				OP_INS_FRONT, OP_INS_END: begin
					if (n_elems >= CAPACITY)
						res.status = ST_FULL;
					else
						open_gap((op == OP_INS_FRONT) ? 0 : n_elems, val);
				end
				OP_INS_POS: begin
					if (n_elems >= CAPACITY)
						res.status = ST_FULL;
					else if (n_elems == 0)
						open_gap(0, val); // position ignored on an empty list
					else if (p < 1 || p > n_elems + 1)
						res.status = ST_BADPOS;
					else
						open_gap(p - 1, val);
				end
				OP_DEL_POS: begin
					if (n_elems == 0)
						res.status = ST_EMPTY;
					else if (p < 1 || p > n_elems)
						res.status = ST_BADPOS;
					else
						close_gap(p - 1);
				end
				OP_READ: begin
					if (n_elems == 0)
						res.status = ST_EMPTY;
					else if (p < 1 || p > n_elems)
						res.status = ST_BADPOS;
					else
						res.read_value = slots[p - 1];
				end
				default: ; // unused codes leave the list alone
			endcase
			res.length   = LEN_W'(n_elems);
			res.is_empty = (n_elems == 0);
			res.is_full  = (n_elems == CAPACITY);
			owed.push_back(res);
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$error("%s mismatch: expected %0h, actual %0h", name, want, got);
				failures++;
			end
		endfunction

		function void check_result(logic [OUT_W-1:0] word);
			list_result_t want;
			if (owed.size() == 0) begin
				$error("result %0h arrived with no operation outstanding", word);
				failures++;
				return;
			end
			want = owed.pop_front();
			compare_field("status", 32'(want.status), 32'(word[1:0]));
			compare_field("length", 32'(want.length), 32'(word[9:2]));
			compare_field("is_empty", 32'(want.is_empty), 32'(word[10]));
			compare_field("is_full", 32'(want.is_full), 32'(word[11]));
			compare_field("read_value", want.read_value, word[43:12]);
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	logic [IN_W-1:0]  s_tdata;
	logic             s_tvalid;
	logic             s_tready;
	logic [OUT_W-1:0] m_tdata;
	logic             m_tvalid;
	logic             m_tready;

	list_scoreboard sb = new();

	// percent of cycles in which each side holds off
	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;
	int unsigned quiet_cycles;
	// random walk direction: grow toward full, or shrink toward empty
	bit          filling;

	array_list_insert_delete_core DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tdata  (m_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// receiver side: fresh stall decision every cycle
	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// monitor: check the outgoing transaction before noting the incoming one,
	// so a result leaving in the same cycle pairs with the older operation
	always @(posedge clk) begin
		if (m_tvalid && m_tready)
			sb.check_result(m_tdata);
		if (s_tvalid && s_tready)
			sb.note_request(s_tdata[2:0], s_tdata[10:3], s_tdata[42:11]);
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	// watchdog: no transaction on either side for too long
	initial begin
		wait (quiet_cycles >= WATCHDOG_LIMIT);
		$display("FAIL");
		$finish;
	end

	// entered and left at a falling edge; one drive of s_tvalid per edge
	task automatic send_item(logic [2:0] op, logic [POS_W-1:0] pos, elem_t val);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tdata  <= {5'b0, val, pos, op};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	// hold the sender until the core owes nothing
	task automatic drain_results();
		s_tvalid <= 1'b0;
		do @(negedge clk); while (sb.pending() != 0);
	endtask

	// next random operation, steered by the shadow length
	task automatic send_random_item();
		logic [2:0]       op;
		logic [POS_W-1:0] pos;
		elem_t            val;
		int unsigned      n;
		int unsigned      r;
		n = sb.n_elems;
		if (n == CAPACITY && $urandom_range(3) == 0)
			filling = 1'b0;
		else if (n == 0 && $urandom_range(3) == 0)
			filling = 1'b1;
		r = $urandom_range(99);
		if (filling)
			op = (r < 20) ? OP_INS_FRONT : (r < 40) ? OP_INS_END : (r < 65) ? OP_INS_POS :
				(r < 78) ? OP_DEL_POS : (r < 96) ? OP_READ : OP_READ + 3'($urandom_range(1, 3));
		else
			op = (r < 5) ? OP_INS_FRONT : (r < 10) ? OP_INS_END : (r < 15) ? OP_INS_POS :
				(r < 70) ? OP_DEL_POS : (r < 96) ? OP_READ : OP_READ + 3'($urandom_range(1, 3));
		// mostly in range, with zero, the first slot past the end and noise
		r = $urandom_range(99);
		if (r < 80 && n != 0)
			pos = POS_W'($urandom_range(1, (op == OP_INS_POS) ? n + 1 : n));
		else if (r < 85)
			pos = '0;
		else if (r < 90)
			pos = POS_W'((op == OP_INS_POS) ? n + 2 : n + 1);
		else
			pos = POS_W'($urandom_range(255));
		r = $urandom_range(99);
		val = (r < 5) ? 32'h8000_0000 : (r < 10) ? 32'h7fff_ffff : elem_t'($urandom);
		send_item(op, pos, val);
	endtask

	initial begin
		arst_n         = 1'b0;
		s_tdata        = '0;
		s_tvalid       = 1'b0;
		filling        = 1'b1;
		send_idle_pct  = 8;
		recv_stall_pct = 79;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// empty list: read and delete report empty, unused codes are no-ops
		send_item(OP_READ, 8'd1, 32'h0);
		send_item(OP_DEL_POS, 8'd1, 32'h0);
		for (int k = 1; k <= 3; k++)
			send_item(OP_READ + 3'(k), 8'hff, 32'hffff_ffff);
		// positional insert on an empty list ignores the position
		send_item(OP_INS_POS, 8'd0, 32'h7fff_ffff);
		send_item(OP_INS_FRONT, 8'd0, 32'h8000_0000);
		send_item(OP_INS_END, 8'd0, 32'hffff_ffff);
		send_item(OP_INS_END, 8'hff, 32'h0);
		// four elements now: insert outside 1..5 is rejected
		send_item(OP_INS_POS, 8'd0, 32'h1111_1111);
		send_item(OP_INS_POS, 8'd6, 32'h2222_2222);
		send_item(OP_INS_POS, 8'hff, 32'h3333_3333);
		send_item(OP_INS_POS, 8'd5, 32'h5555_aaaa);
		send_item(OP_INS_POS, 8'd3, 32'h1234_5678);
		send_item(OP_INS_POS, 8'd1, 32'haaaa_5555);
		// seven elements: reads and deletes at both ends and out of range
		send_item(OP_READ, 8'd1, 32'h0);
		send_item(OP_READ, 8'd7, 32'h0);
		send_item(OP_READ, 8'd0, 32'h0);
		send_item(OP_READ, 8'd8, 32'h0);
		send_item(OP_DEL_POS, 8'd0, 32'h0);
		send_item(OP_DEL_POS, 8'd8, 32'h0);
		send_item(OP_DEL_POS, 8'd7, 32'h0);
		send_item(OP_DEL_POS, 8'd1, 32'h0);
		send_item(OP_DEL_POS, 8'd3, 32'h0);
		send_item(OP_READ, 8'd3, 32'h0);

		// three idling profiles, each entered with nothing outstanding
		for (int phase = 0; phase < 3; phase++) begin
			drain_results();
			send_idle_pct  = (phase == 0) ? 8 : (phase == 1) ? 79 : 0;
			recv_stall_pct = (phase == 0) ? 79 : (phase == 1) ? 8 : 0;
			for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
				// now and then let the output side catch up completely
				if ($urandom_range(99) == 0)
					drain_results();
				send_random_item();
			end
		end

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.failures == 0 && sb.pending() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

[array_list_insert_delete_core.f]
rtl/core/alid_pkg.sv
rtl/core/alid_cell.sv
rtl/core/alid_chain.sv
rtl/core/array_list_insert_delete_core.sv
test/tb_array_list_insert_delete_core.sv
